// File: src/ascii_hex_response_deframer_core_defines.svh
// assertion macros for the ascii hex response deframer
`ifndef ASCII_HEX_RESPONSE_DEFRAMER_CORE_DEFINES_SVH
`define ASCII_HEX_RESPONSE_DEFRAMER_CORE_DEFINES_SVH

// concurrent assertion on clk_i, disabled while rst_ni is low
`define AHRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// concurrent assertion on clk_i that also holds during reset
`define AHRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/ahrd_pkg.sv
// types, character codes and hex decode shared by the deframer files
package ahrd_pkg;

  typedef enum logic {
    CMD_ARM  = 1'b0,
    CMD_BYTE = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_ACK        = 3'd0,
    ST_NAK        = 3'd1,
    ST_DATA_OK    = 3'd2,
    ST_CSUM_ERR   = 3'd3,
    ST_FORMAT_ERR = 3'd4
  } status_e;

  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;

  localparam int unsigned PosW = 10;

  // '0'..'9' and anything below give c-0x30, the rest c-0x37, low nibble kept
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] diff;
    if (c <= 8'h39) begin
      diff = c - 8'h30;
    end else begin
      diff = c - 8'h37;
    end
    return diff[3:0];
  endfunction

endpackage

// File: src/ascii_hex_response_deframer_core.sv
// reply frame checker for an stx/etx ascii hex link with an 8-bit sum checksum
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------------
//   in      | in_valid_i/ready_o  | cmd_i, expect_read_i, data_len_i, rx_byte_i
//   out     | out_valid_o/ready_i | kind_o, data_byte_o, byte_index_o, status_o
//
// one item per cycle while the result side is not stalled: each item is decoded in a
// single pass of logic from the transaction state into the result register, so the
// result shows in the cycle after the item is taken
// the result register parts the two sides: a new item is taken whenever the
// result register is empty or its result is taken in the same cycle
// reset clears the transaction state and the result valid flag
module ascii_hex_response_deframer_core
  import ahrd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic       expect_read_i,
  input  logic [7:0] data_len_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [7:0] data_byte_o,
  output logic [7:0] byte_index_o,
  output logic [2:0] status_o
);

  // transaction state
  logic            armed_q, armed_d;
  logic [PosW-1:0] len_q, len_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      sum_q, sum_d;
  logic [3:0]      hnib_q, hnib_d;
  logic            etx_q, etx_d;

  // result register
  logic            out_valid_q, out_valid_d;
  kind_e           kind_q, kind_d;
  logic [7:0]      dbyte_q, dbyte_d;
  logic [7:0]      bidx_q, bidx_d;
  status_e         status_q, status_d;

  logic            in_acc;
  logic            res_valid;

  // pass-through helpers for the decode
  logic [PosW:0]   idx_p3;
  logic [PosW:0]   idx_p2;
  logic [PosW:0]   len_x;
  logic [3:0]      nib;
  logic [7:0]      fb;
  logic [7:0]      recv;
  logic [PosW-1:0] half_idx;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  assign idx_p3   = {1'b0, pos_q} + (PosW+1)'(3);
  assign idx_p2   = {1'b0, pos_q} + (PosW+1)'(2);
  assign len_x    = {1'b0, len_q};
  assign nib      = hex_nibble(rx_byte_i);
  assign recv     = {hnib_q, nib};
  assign half_idx = (pos_q >> 1) - PosW'(1);

  // decode one item against the transaction state
  always_comb begin
    armed_d   = armed_q;
    len_d     = len_q;
    pos_d     = pos_q;
    first_d   = first_q;
    sum_d     = sum_q;
    hnib_d    = hnib_q;
    etx_d     = etx_q;
    res_valid = 1'b0;
    kind_d    = KIND_STATUS;
    dbyte_d   = 8'h00;
    bidx_d    = 8'h00;
    status_d  = ST_ACK;
    fb        = first_q;

    if (in_acc) begin
      if (cmd_e'(cmd_i) == CMD_ARM) begin
        // start over; a running transaction is dropped silently
        armed_d = 1'b1;
        len_d   = expect_read_i ? ({1'b0, data_len_i, 1'b0} + PosW'(4)) : PosW'(1);
        pos_d   = '0;
        first_d = 8'h00;
        sum_d   = 8'h00;
        hnib_d  = 4'h0;
        etx_d   = 1'b0;
      end else if (armed_q && (pos_q < len_q)) begin
        pos_d = pos_q + PosW'(1);
        if (pos_q == '0) begin
          first_d = rx_byte_i;
          fb      = rx_byte_i;
          if (rx_byte_i == CH_NAK) begin
            // leading nak closes the transaction at once
            armed_d   = 1'b0;
            res_valid = 1'b1;
            status_d  = ST_NAK;
          end
        end else if (idx_p3 <= len_x) begin
          sum_d = sum_q + rx_byte_i;
          if (idx_p3 == len_x) begin
            etx_d = (rx_byte_i == CH_ETX);
          end else if (pos_q[0]) begin
            hnib_d = nib;
          end else begin
            // second character of a pair: provisional data byte
            res_valid = 1'b1;
            kind_d    = KIND_DATA;
            dbyte_d   = {hnib_q, nib};
            bidx_d    = half_idx[7:0];
          end
        end else if (idx_p2 == len_x) begin
          hnib_d = nib;
        end

        // last expected byte: final status
        if (!res_valid && (pos_d == len_q)) begin
          armed_d   = 1'b0;
          res_valid = 1'b1;
          if (fb == CH_ACK) begin
            status_d = ST_ACK;
          end else if (fb == CH_NAK) begin
            status_d = ST_NAK;
          end else if ((fb == CH_STX) && (len_q > PosW'(3)) && etx_q) begin
            status_d = (recv == sum_q) ? ST_DATA_OK : ST_CSUM_ERR;
          end else begin
            status_d = ST_FORMAT_ERR;
          end
        end
      end
    end
  end

  // result register valid: set by a new result, held while stalled
  always_comb begin
    if (in_acc) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      len_q       <= '0;
      pos_q       <= '0;
      first_q     <= 8'h00;
      sum_q       <= 8'h00;
      hnib_q      <= 4'h0;
      etx_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      armed_q     <= armed_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      first_q     <= first_d;
      sum_q       <= sum_d;
      hnib_q      <= hnib_d;
      etx_q       <= etx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      kind_q   <= kind_d;
      dbyte_q  <= dbyte_d;
      bidx_q   <= bidx_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign data_byte_o  = dbyte_q;
  assign byte_index_o = bidx_q;
  assign status_o     = status_q;

endmodule

// File: src/ahrd_checker.sv
// port level checks for the deframer and their bind to the top level
`include "ascii_hex_response_deframer_core_defines.svh"

module ahrd_checker
  import ahrd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       cmd_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       kind_o,
  input logic [7:0] data_byte_o,
  input logic [7:0] byte_index_o,
  input logic [2:0] status_o
);

  `AHRD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(status_o), "stalled result changed")
  `AHRD_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_o |-> in_ready_o, "not ready with empty output")
  `AHRD_ASSERT(a_data_status_zero, out_valid_o && (kind_o == KIND_DATA) |-> status_o == ST_ACK, "data item with nonzero status")
  `AHRD_ASSERT(a_status_fields_zero, out_valid_o && (kind_o == KIND_STATUS) |-> data_byte_o == 8'h00 && byte_index_o == 8'h00, "status item with data fields")
  `AHRD_ASSERT(a_arm_no_result, in_valid_i && in_ready_o && (cmd_i == CMD_ARM) && !(out_valid_o && !out_ready_i) |=> !out_valid_o, "arm item produced a result")

endmodule

bind ascii_hex_response_deframer_core ahrd_checker u_ahrd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .cmd_i        (cmd_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .kind_o       (kind_o),
  .data_byte_o  (data_byte_o),
  .byte_index_o (byte_index_o),
  .status_o     (status_o)
);

// File: tb/ascii_hex_response_deframer_core_test.sv
// self-checking testbench for the ascii hex reply deframer core
`timescale 1ns / 100ps

module ascii_hex_response_deframer_core_test;
  import ahrd_pkg::*;

  // cycles with no handshake on either side before the run is called hung
  localparam int unsigned StallLimit = 400;
  // input items taken before random traffic stops, directed tests included
  localparam int unsigned TotalItems = 600;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    status_e    status;
  } reply_t;

  // ways a generated read frame can be damaged
  typedef enum int {
    FLAW_NONE,
    FLAW_CSUM,
    FLAW_ETX,
    FLAW_LEAD,
    FLAW_TRUNC,
    FLAW_EXTRA,
    FLAW_JUNK
  } flaw_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       cmd_i;
  logic       expect_read_i;
  logic [7:0] data_len_i;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       kind_o;
  logic [7:0] data_byte_o;
  logic [7:0] byte_index_o;
  logic [2:0] status_o;

  // shadow of the transaction state
  bit         armed;
  logic [9:0] frame_len;
  logic [9:0] frame_pos;
  logic [7:0] lead_byte;
  logic [7:0] frame_sum;
  logic [3:0] hi_nib;
  bit         etx_ok;

  reply_t owed_replies[$];

  int unsigned in_taken;
  int unsigned out_taken;
  int unsigned live_items;
  int unsigned data_seen;
  int unsigned status_seen[5];
  int unsigned fault_count;
  bit          in_idle_on;
  bit          out_idle_on;

  ascii_hex_response_deframer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .expect_read_i (expect_read_i),
    .data_len_i    (data_len_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .data_byte_o   (data_byte_o),
    .byte_index_o  (byte_index_o),
    .status_o      (status_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // digits and anything below '9' count from '0', the rest from 'A' - 10
  function automatic logic [3:0] ascii_nibble(logic [7:0] ch);
    logic [7:0] offset;
    offset = (ch <= 8'h39) ? 8'h30 : 8'h37;
    return 4'(ch - offset);
  endfunction

  function automatic void owe_status(status_e st);
    owed_replies.push_back('{kind: KIND_STATUS, data_byte: 8'h00, byte_index: 8'h00,
                             status: st});
  endfunction

  // advance the shadow state by one item and queue the reply it causes
  function automatic void deframe_item(cmd_e c, logic rd, logic [7:0] len, logic [7:0] b);
    logic [9:0] idx;
    status_e    st;
    if (c == CMD_ARM) begin
      // a new arm drops whatever transaction was running
      armed     = 1'b1;
      frame_len = rd ? 10'(len) * 10'd2 + 10'd4 : 10'd1;
      frame_pos = '0;
      lead_byte = '0;
      frame_sum = '0;
      hi_nib    = '0;
      etx_ok    = 1'b0;
      return;
    end
    // bytes outside a transaction or past its length fall on the floor
    if (!armed || frame_pos >= frame_len) return;
    idx = frame_pos;
    frame_pos = frame_pos + 10'd1;
    if (idx == 10'd0) begin
      lead_byte = b;
      // a leading nak closes the transaction at once
      if (b == CH_NAK) begin
        armed = 1'b0;
        owe_status(ST_NAK);
        return;
      end
    end else if (idx + 10'd3 <= frame_len) begin
      frame_sum = frame_sum + b;
      if (idx + 10'd3 == frame_len) begin
        etx_ok = (b == CH_ETX);
      end else if (idx[0]) begin
        hi_nib = ascii_nibble(b);
      end else begin
        // second char of a pair: provisional data byte
        owed_replies.push_back('{kind: KIND_DATA, data_byte: {hi_nib, ascii_nibble(b)},
                                 byte_index: 8'((idx >> 1) - 10'd1), status: ST_ACK});
        return;
      end
    end else if (idx + 10'd2 == frame_len) begin
      hi_nib = ascii_nibble(b);
    end
    if (frame_pos == frame_len) begin
      armed = 1'b0;
      if (lead_byte == CH_ACK) begin
        st = ST_ACK;
      end else if (lead_byte == CH_NAK) begin
        st = ST_NAK;
      end else if (lead_byte == CH_STX && frame_len > 10'd3 && etx_ok) begin
        st = ({hi_nib, ascii_nibble(b)} == frame_sum) ? ST_DATA_OK : ST_CSUM_ERR;
      end else begin
        st = ST_FORMAT_ERR;
      end
      owe_status(st);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // monitor and checker, sampled at the rising edge
  // ---------------------------------------------------------------------------

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni) begin
      // results first: a result never belongs to the item taken at the same edge
      if (out_valid_o && out_ready_i) begin
        out_taken++;
        if (kind_o == KIND_DATA) begin
          data_seen++;
        end else if (status_o <= 3'd4) begin
          status_seen[status_o]++;
        end
        if (owed_replies.size() == 0) begin
          note_fault($sformatf("unexpected result: kind %0d byte %02h index %0d status %0d",
                               kind_o, data_byte_o, byte_index_o, status_o));
        end else begin
          want = owed_replies.pop_front();
          if (kind_o !== want.kind || data_byte_o !== want.data_byte ||
              byte_index_o !== want.byte_index || status_o !== want.status) begin
            note_fault($sformatf({"mismatch: expected kind %0d byte %02h index %0d ",
                                  "status %0d, got kind %0d byte %02h index %0d status %0d"},
                                 want.kind, want.data_byte, want.byte_index, want.status,
                                 kind_o, data_byte_o, byte_index_o, status_o));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        in_taken++;
        if (cmd_i == CMD_ARM || (armed && frame_pos < frame_len)) live_items++;
        deframe_item(cmd_e'(cmd_i), expect_read_i, data_len_i, rx_byte_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: a fresh random stall, possibly none, after each result taken
  // ---------------------------------------------------------------------------

  int unsigned stall_left;
  int unsigned stall_mark;

  always @(negedge clk_i) begin
    if (out_taken != stall_mark) begin
      stall_mark = out_taken;
      stall_left = out_idle_on ? $urandom_range(0, 9) : 0;
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // item side
  // ---------------------------------------------------------------------------

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_item(cmd_e c, logic rd, logic [7:0] len, logic [7:0] b);
    int unsigned gap;
    int unsigned mark;
    gap = in_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= c;
    expect_read_i <= rd;
    data_len_i    <= len;
    rx_byte_i     <= b;
    mark = in_taken;
    do @(negedge clk_i); while (in_taken == mark);
  endtask

  // unused fields get random values so every input bit moves
  task automatic arm(logic rd, logic [7:0] len);
    send_item(CMD_ARM, rd, len, 8'($urandom));
  endtask

  task automatic put_byte(logic [7:0] b);
    send_item(CMD_BYTE, 1'($urandom), 8'($urandom), b);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h57 : 8'h37) + 8'(n);
  endfunction

  // arm for a read and send a frame of random data, damaged as asked
  task automatic send_read_frame(int unsigned dlen, flaw_e flaw);
    logic [7:0]  frame[$];
    logic [7:0]  sum;
    logic [7:0]  val;
    logic [7:0]  ch;
    bit          lower;
    int unsigned cut;
    sum = '0;
    lower = $urandom_range(0, 1);
    frame.push_back(CH_STX);
    for (int unsigned i = 0; i < 2 * dlen; i++) begin
      if (i[0] == 1'b0) val = 8'($urandom);
      ch = hex_char(i[0] ? val[3:0] : val[7:4], lower);
      // junk frames carry arbitrary bytes where hex digits belong
      if (flaw == FLAW_JUNK && $urandom_range(0, 3) == 0) ch = 8'($urandom);
      frame.push_back(ch);
      sum += ch;
    end
    ch = CH_ETX;
    if (flaw == FLAW_ETX) begin
      ch = 8'($urandom);
      if (ch == CH_ETX) ch = CH_ACK;
    end
    frame.push_back(ch);
    sum += ch;
    if (flaw == FLAW_CSUM) sum ^= 8'(1 << $urandom_range(0, 7));
    frame.push_back(hex_char(sum[7:4], lower));
    frame.push_back(hex_char(sum[3:0], lower));
    if (flaw == FLAW_LEAD) begin
      case ($urandom_range(0, 2))
        0:       frame[0] = CH_ACK;
        1:       frame[0] = CH_NAK;
        default: frame[0] = 8'($urandom);
      endcase
    end
    cut = (flaw == FLAW_TRUNC) ? $urandom_range(0, frame.size() - 1) : frame.size();
    arm(1'b1, 8'(dlen));
    for (int unsigned i = 0; i < cut; i++) put_byte(frame[i]);
    // bytes past the frame length are dropped
    if (flaw == FLAW_EXTRA) repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
  endtask

  // write-style reply: one byte, sometimes followed by a stray byte
  task automatic send_short_reply();
    logic [7:0] lead;
    case ($urandom_range(0, 3))
      0:       lead = CH_ACK;
      1:       lead = CH_NAK;
      2:       lead = CH_STX;
      default: lead = 8'($urandom);
    endcase
    arm(1'b0, 8'($urandom));
    put_byte(lead);
    if ($urandom_range(0, 3) == 0) put_byte(8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // one-byte replies: ack, nak and a lone stx giving a format error
  task automatic test_single_byte_replies();
    arm(1'b0, 8'h00);
    put_byte(CH_ACK);
    arm(1'b0, 8'hff);
    put_byte(CH_NAK);
    arm(1'b0, 8'h5a);
    put_byte(CH_STX);
  endtask

  // nak as first byte of a read ends it early, the next byte is ignored
  task automatic test_leading_nak();
    arm(1'b1, 8'h05);
    put_byte(CH_NAK);
    put_byte(8'h30);
  endtask

  // read of zero data bytes: stx, etx, checksum "03"
  task automatic test_empty_read();
    arm(1'b1, 8'h00);
    put_byte(CH_STX);
    put_byte(CH_ETX);
    put_byte(8'h30);
    put_byte(8'h33);
  endtask

  // abandoned read, then odd hex characters: 0x00, 0xff, 'A' and '/'
  // with a checksum that does not match
  task automatic test_hex_corners();
    arm(1'b1, 8'h07);
    put_byte(CH_STX);
    put_byte(8'h31);
    arm(1'b1, 8'h02);
    put_byte(CH_STX);
    put_byte(8'h00);
    put_byte(8'hff);
    put_byte(8'h41);
    put_byte(8'h2f);
    put_byte(CH_ETX);
    put_byte(8'h30);
    put_byte(8'h30);
  endtask

  // longest read frame, reaching the top data index
  task automatic test_longest_frame();
    send_read_frame(255, FLAW_NONE);
  endtask

  // well-formed frames with random data (half of the picks), mixed with damaged frames,
  // one-byte replies and stray bytes; idling is switched per stretch
  task automatic test_random_traffic();
    int unsigned txn;
    int unsigned pick;
    int unsigned dlen;
    txn = 0;
    while (in_taken < TotalItems) begin
      if (txn % 8 == 0) begin
        in_idle_on  = $urandom_range(0, 3) != 0;
        out_idle_on = $urandom_range(0, 3) != 0;
      end
      txn++;
      dlen = ($urandom_range(0, 39) == 0) ? $urandom_range(9, 64) : $urandom_range(0, 8);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_read_frame(dlen, FLAW_NONE);
      end else if (pick < 80) begin
        send_read_frame(dlen, flaw_e'($urandom_range(FLAW_CSUM, FLAW_JUNK)));
      end else if (pick < 92) begin
        send_short_reply();
      end else begin
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
      end
    end
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = CMD_ARM;
    expect_read_i = 1'b0;
    data_len_i    = 8'h00;
    rx_byte_i     = 8'h00;
    out_ready_i   = 1'b0;
    in_idle_on    = 1'b1;
    out_idle_on   = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_single_byte_replies();
    test_leading_nak();
    test_empty_read();
    test_hex_corners();
    test_longest_frame();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (owed_replies.size() != 0) @(negedge clk_i);
    // the core is one result register deep, so any extra result shows up in this wait
    repeat (8) @(negedge clk_i);
    if (owed_replies.size() != 0) begin
      note_fault($sformatf("%0d expected results never arrived", owed_replies.size()));
    end

    $display("%0d items taken (%0d acted on), %0d data bytes and %0d results checked",
             in_taken, live_items, data_seen, out_taken);
    $display("statuses: ack %0d, nak %0d, data_ok %0d, checksum_error %0d, format_error %0d",
             status_seen[ST_ACK], status_seen[ST_NAK], status_seen[ST_DATA_OK],
             status_seen[ST_CSUM_ERR], status_seen[ST_FORMAT_ERR]);
    if (fault_count == 0) begin
      $display("ascii_hex_response_deframer_core test passed");
    end else begin
      $display("ascii_hex_response_deframer_core test failed");
    end
    $finish;
  end

  // hang guard: any handshake restarts the count
  initial begin : watchdog
    int unsigned quiet;
    int unsigned last_moves;
    quiet = 0;
    last_moves = 0;
    while (quiet < StallLimit) begin
      @(negedge clk_i);
      if (in_taken + out_taken != last_moves) begin
        last_moves = in_taken + out_taken;
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout after %0d cycles without a handshake", StallLimit);
    $display("ascii_hex_response_deframer_core test failed");
    $finish;
  end

endmodule
